@@ hdl/varu_pkg.sv @@
// ----------------------------------------------------------------------------
// varu_pkg
// Shared widths, lane tables, word types and helpers for the vector
// alignment rotation unit.
// ----------------------------------------------------------------------------
package varu_pkg;

	// quadratic lanes: the six distinct products W_i*W_j (the matrix is symmetric)
	localparam int NQ      = 6;
	localparam int QBITS   = 19;
	localparam int REMW    = 66;
	localparam int QSUMW   = 32;
	localparam int ONE_Q14 = 16384;

	localparam logic [1:0] LANE_I [NQ] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd1};
	localparam logic [1:0] LANE_J [NQ] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

	// divider state that moves from one step to the next
	typedef struct packed {
		logic [NQ-1:0][REMW-1:0]  rem;
		logic [NQ-1:0][QBITS-1:0] quo;
		logic [QSUMW-1:0]         qsum;
	} div_t;

	// word fields that ride alongside the divider
	typedef struct packed {
		logic                     degen;
		logic [2:0][19:0]         lin_cr;
		logic [19:0]              lin_dot;
		logic [NQ-1:0]            qneg;
	} side_t;

	// round scale 2^28 to 2^14, nearest, ties away from zero
	function automatic logic signed [19:0] rnd14(input logic signed [34:0] x);
		logic [34:0] mag;
		logic [34:0] t;
		mag = x[34] ? 35'(-x) : 35'(x);
		t   = (mag + 35'd8192) >> 14;
		rnd14 = x[34] ? -$signed(t[19:0]) : $signed(t[19:0]);
	endfunction

	// clamp to signed 20 bits
	function automatic logic [19:0] sat20(input logic signed [21:0] x);
		if (x > 22'sd524287)
			sat20 = 20'h7FFFF;
		else if (x < -22'sd524288)
			sat20 = 20'h80000;
		else
			sat20 = x[19:0];
	endfunction

endpackage

@@ hdl/varu_in_if.sv @@
// ----------------------------------------------------------------------------
// varu_in_if
// Input channel: one word carries the two Q1.14 vectors a and b.
// ----------------------------------------------------------------------------
interface varu_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] a_x;
	logic signed [15:0] a_y;
	logic signed [15:0] a_z;
	logic signed [15:0] b_x;
	logic signed [15:0] b_y;
	logic signed [15:0] b_z;

	modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
	modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

@@ hdl/varu_out_if.sv @@
// ----------------------------------------------------------------------------
// varu_out_if
// Output channel: one word carries the 3x3 rotation in Q5.14 and a flag.
// ----------------------------------------------------------------------------
interface varu_out_if;
	logic               valid;
	logic               ready;
	logic signed [19:0] r00;
	logic signed [19:0] r01;
	logic signed [19:0] r02;
	logic signed [19:0] r10;
	logic signed [19:0] r11;
	logic signed [19:0] r12;
	logic signed [19:0] r20;
	logic signed [19:0] r21;
	logic signed [19:0] r22;
	logic               degenerate;

	modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, degenerate,
		input ready);
	modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, degenerate,
		output ready);
endinterface

@@ hdl/varu_div_step.sv @@
// ----------------------------------------------------------------------------
// varu_div_step
// One registered restoring-division step for all six quadratic lanes.
// Produces quotient bit BIT of rem / (qsum << 14).
// ----------------------------------------------------------------------------
module varu_div_step #(
	parameter int BIT = 0
) (
	input  logic            clk,
	input  logic            en,
	input  varu_pkg::div_t  div_d,
	input  varu_pkg::side_t side_d,
	output varu_pkg::div_t  div_q,
	output varu_pkg::side_t side_q
);

	localparam int SHIFT = 14 + BIT;

	logic [varu_pkg::REMW-1:0] trial;
	varu_pkg::div_t            nxt;

	// compare and subtract per lane
	always_comb begin
		trial = varu_pkg::REMW'(div_d.qsum) << SHIFT;
		nxt   = div_d;
		for (int l = 0; l < varu_pkg::NQ; l++) begin
			if (div_d.rem[l] >= trial) begin
				nxt.rem[l]      = div_d.rem[l] - trial;
				nxt.quo[l][BIT] = 1'b1;
			end
		end
	end

	// advance when the stage is free to move
	always_ff @(posedge clk) begin
		if (en) begin
			div_q  <= nxt;
			side_q <= side_d;
		end
	end

endmodule

@@ hdl/vector_alignment_rotation_unit.sv @@
// ----------------------------------------------------------------------------
// vector_alignment_rotation_unit
// Rotation that turns vector a onto vector b, Rodrigues form, Q5.14 output.
// ----------------------------------------------------------------------------
// A fully pipelined unit: it takes one vector pair every clock unless
// back-pressure has filled its stages. Seven stages form the
// products, cross and dot products, rounding, normalisation of the cross
// product and the numerator and denominator of the quadratic term; nineteen
// restoring-division stages (one quotient bit each, six lanes in parallel
// because the quadratic term is symmetric) follow, then an output register
// that adds, saturates and selects the identity when the cross product is
// zero. Each stage holds its own valid bit, so bubbles close up under
// back-pressure and a stalled output does not stop the input while free
// stages remain.
// ----------------------------------------------------------------------------
module vector_alignment_rotation_unit (
	input  logic          clk,
	input  logic          arst_n,
	varu_in_if.sink       vec,
	varu_out_if.source    rot
);

	localparam int NFRONT = 7;
	localparam int NDIV   = varu_pkg::QBITS;
	localparam int NS     = NFRONT + NDIV + 1;

	localparam logic [2:0] QIDX [3][3] = '{'{3'd0, 3'd3, 3'd4},
		'{3'd3, 3'd1, 3'd5}, '{3'd4, 3'd5, 3'd2}};

	logic [NS-1:0] v_q;
	logic [NS:0]   en;

	// stage enables: a stage moves when empty or when the next one moves
	always_comb begin
		en[NS] = rot.ready;
		for (int k = NS - 1; k >= 0; k--)
			en[k] = !v_q[k] || en[k+1];
	end

	assign vec.ready = en[0];
	assign rot.valid = v_q[NS-1];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0])
				v_q[0] <= vec.valid;
			for (int k = 1; k < NS; k++) begin
				if (en[k])
					v_q[k] <= v_q[k-1];
			end
		end
	end

	// stage 1: products of inputs
	logic signed [31:0] pr_s1 [9];
	always_ff @(posedge clk) begin
		if (en[0]) begin
			pr_s1[0] <= vec.a_y * vec.b_z;
			pr_s1[1] <= vec.a_z * vec.b_y;
			pr_s1[2] <= vec.a_z * vec.b_x;
			pr_s1[3] <= vec.a_x * vec.b_z;
			pr_s1[4] <= vec.a_x * vec.b_y;
			pr_s1[5] <= vec.a_y * vec.b_x;
			pr_s1[6] <= vec.a_x * vec.b_x;
			pr_s1[7] <= vec.a_y * vec.b_y;
			pr_s1[8] <= vec.a_z * vec.b_z;
		end
	end

	// stage 2: cross and dot products
	logic signed [32:0] cr_s2 [3];
	logic signed [33:0] dot_s2;
	always_ff @(posedge clk) begin
		if (en[1]) begin
			cr_s2[0] <= 33'(pr_s1[0]) - 33'(pr_s1[1]);
			cr_s2[1] <= 33'(pr_s1[2]) - 33'(pr_s1[3]);
			cr_s2[2] <= 33'(pr_s1[4]) - 33'(pr_s1[5]);
			dot_s2   <= 34'(pr_s1[6]) + 34'(pr_s1[7]) + 34'(pr_s1[8]);
		end
	end

	// stage 3: magnitudes, leading one of the largest, rounding, 1 - c
	logic [31:0]        crm_c [3];
	logic [31:0]        orv_c;
	logic [4:0]         pos_c;
	logic signed [34:0] dm_c;
	always_comb begin
		for (int i = 0; i < 3; i++)
			crm_c[i] = cr_s2[i][32] ? 32'(-cr_s2[i]) : 32'(cr_s2[i]);
		orv_c = crm_c[0] | crm_c[1] | crm_c[2];
		pos_c = '0;
		for (int b = 0; b < 32; b++)
			if (orv_c[b])
				pos_c = 5'(b);
		dm_c = 35'sd268435456 - 35'(dot_s2);
	end

	logic [31:0]   crm_s3 [3];
	logic [2:0]    crs_s3;
	logic [4:0]    pos_s3;
	logic [31:0]   dmag_s3;
	logic          dneg_s3;
	varu_pkg::side_t side_s3;
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				crm_s3[i]           <= crm_c[i];
				crs_s3[i]           <= cr_s2[i][32];
				side_s3.lin_cr[i]   <= varu_pkg::rnd14(35'(cr_s2[i]));
			end
			pos_s3          <= pos_c;
			dmag_s3         <= dm_c[34] ? 32'(-dm_c) : 32'(dm_c);
			dneg_s3         <= dm_c[34];
			side_s3.lin_dot <= varu_pkg::rnd14(35'(dot_s2));
			side_s3.degen   <= (orv_c == '0);
			side_s3.qneg    <= '0;
		end
	end

	// stage 4: normalise the cross product so the largest lies in [2^14, 2^15)
	logic [14:0] w_c [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pos_s3 >= 5'd14)
				w_c[i] = 15'(crm_s3[i] >> (pos_s3 - 5'd14));
			else
				w_c[i] = 15'(crm_s3[i] << (5'd14 - pos_s3));
		end
	end

	logic [14:0]     w_s4 [3];
	logic [2:0]      crs_s4;
	logic [31:0]     dmag_s4;
	logic            dneg_s4;
	varu_pkg::side_t side_s4;
	always_ff @(posedge clk) begin
		if (en[3]) begin
			w_s4    <= w_c;
			crs_s4  <= crs_s3;
			dmag_s4 <= dmag_s3;
			dneg_s4 <= dneg_s3;
			side_s4 <= side_s3;
		end
	end

	// stage 5: pair products W_i*W_j
	logic [29:0]     pm_s5 [varu_pkg::NQ];
	logic [varu_pkg::NQ-1:0] ps_s5;
	logic [31:0]     dmag_s5;
	logic            dneg_s5;
	varu_pkg::side_t side_s5;
	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int l = 0; l < varu_pkg::NQ; l++) begin
				pm_s5[l] <= 30'(w_s4[varu_pkg::LANE_I[l]]) * 30'(w_s4[varu_pkg::LANE_J[l]]);
				ps_s5[l] <= crs_s4[varu_pkg::LANE_I[l]] ^ crs_s4[varu_pkg::LANE_J[l]];
			end
			dmag_s5 <= dmag_s4;
			dneg_s5 <= dneg_s4;
			side_s5 <= side_s4;
		end
	end

	// stage 6: sum of squares and numerators P_ij * (1 - c)
	logic [61:0]     nm_s6 [varu_pkg::NQ];
	logic [varu_pkg::QSUMW-1:0] q_s6;
	varu_pkg::side_t side_s6;
	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int l = 0; l < varu_pkg::NQ; l++) begin
				nm_s6[l]        <= 62'(pm_s5[l]) * 62'(dmag_s5);
				side_s6.qneg[l] <= ps_s5[l] ^ dneg_s5;
			end
			q_s6 <= 32'(pm_s5[0]) + 32'(pm_s5[1]) + 32'(pm_s5[2]);
			side_s6.degen   <= side_s5.degen;
			side_s6.lin_cr  <= side_s5.lin_cr;
			side_s6.lin_dot <= side_s5.lin_dot;
		end
	end

	// stage 7: add half the divisor for rounding, clear the quotient
	varu_pkg::div_t  div_s7;
	varu_pkg::side_t side_s7;
	always_ff @(posedge clk) begin
		if (en[6]) begin
			for (int l = 0; l < varu_pkg::NQ; l++) begin
				div_s7.rem[l] <= varu_pkg::REMW'(nm_s6[l]) + (varu_pkg::REMW'(q_s6) << 13);
				div_s7.quo[l] <= '0;
			end
			div_s7.qsum <= q_s6;
			side_s7     <= side_s6;
		end
	end

	// division pipeline, most significant quotient bit first
	varu_pkg::div_t  div_d  [NDIV+1];
	varu_pkg::side_t side_d [NDIV+1];
	assign div_d[0]  = div_s7;
	assign side_d[0] = side_s7;

	for (genvar g = 0; g < NDIV; g++) begin : g_div
		varu_div_step #(
			.BIT (NDIV - 1 - g)
		) u_step (
			.clk    (clk),
			.en     (en[NFRONT + g]),
			.div_d  (div_d[g]),
			.side_d (side_d[g]),
			.div_q  (div_d[g+1]),
			.side_q (side_d[g+1])
		);
	end

	// output stage: linear part plus signed quadratic part, saturate
	logic signed [21:0] lin_c [3][3];
	logic [19:0]        r_c   [3][3];
	varu_pkg::div_t     dv;
	varu_pkg::side_t    sd;
	always_comb begin
		dv = div_d[NDIV];
		sd = side_d[NDIV];
		lin_c[0][0] = 22'($signed(sd.lin_dot));
		lin_c[1][1] = 22'($signed(sd.lin_dot));
		lin_c[2][2] = 22'($signed(sd.lin_dot));
		lin_c[0][1] = -22'($signed(sd.lin_cr[2]));
		lin_c[0][2] = 22'($signed(sd.lin_cr[1]));
		lin_c[1][0] = 22'($signed(sd.lin_cr[2]));
		lin_c[1][2] = -22'($signed(sd.lin_cr[0]));
		lin_c[2][0] = -22'($signed(sd.lin_cr[1]));
		lin_c[2][1] = 22'($signed(sd.lin_cr[0]));
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (sd.degen)
					r_c[i][j] = (i == j) ? 20'(varu_pkg::ONE_Q14) : 20'd0;
				else if (sd.qneg[QIDX[i][j]])
					r_c[i][j] = varu_pkg::sat20(lin_c[i][j]
						- 22'($signed({1'b0, dv.quo[QIDX[i][j]]})));
				else
					r_c[i][j] = varu_pkg::sat20(lin_c[i][j]
						+ 22'($signed({1'b0, dv.quo[QIDX[i][j]]})));
			end
		end
	end

	logic [19:0] r_s27 [3][3];
	logic        degen_s27;
	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			r_s27     <= r_c;
			degen_s27 <= sd.degen;
		end
	end

	assign rot.r00        = r_s27[0][0];
	assign rot.r01        = r_s27[0][1];
	assign rot.r02        = r_s27[0][2];
	assign rot.r10        = r_s27[1][0];
	assign rot.r11        = r_s27[1][1];
	assign rot.r12        = r_s27[1][2];
	assign rot.r20        = r_s27[2][0];
	assign rot.r21        = r_s27[2][1];
	assign rot.r22        = r_s27[2][2];
	assign rot.degenerate = degen_s27;

endmodule

@@ test/tb_vector_alignment_rotation_unit.sv @@
// ----------------------------------------------------------------------------
// tb_vector_alignment_rotation_unit
// Self-checking bench for the vector alignment rotation unit: directed and
// random vector pairs, bursty input, patterned output stalls, one long hold.
// ----------------------------------------------------------------------------
module tb_vector_alignment_rotation_unit;

	typedef struct {
		logic signed [15:0] ax, ay, az, bx, by, bz;
	} pair_t;

	typedef struct {
		logic signed [19:0] r [9];
		logic               degen;
	} rot_t;

	localparam int N_RANDOM  = 1930;
	localparam int CYC_LIMIT = 400000;
	localparam int LATENCY   = 27;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	varu_in_if  vec ();
	varu_out_if rot ();

	vector_alignment_rotation_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vec    (vec.sink),
		.rot    (rot.source)
	);

	pair_t pending_pairs [$];
	rot_t  expected_rots [$];
	int    n_errors = 0;
	int    n_checked = 0;
	int    n_degen = 0;
	int    n_sat = 0;
	int    cycle = 0;
	bit    all_queued = 1'b0;
	int    hold_cycles = 0;
	bit    hold_done = 1'b0;

	always #4 clk = ~clk;

	// magnitude of a signed 64-bit value
	function automatic logic [63:0] mag64(input logic signed [63:0] x);
		return x < 0 ? 64'(-x) : 64'(x);
	endfunction

	// nearest division, ties away from zero, den > 0
	function automatic logic signed [63:0] div_nearest(input logic signed [63:0] num,
		input logic signed [63:0] den);
		logic [63:0] q;
		q = (mag64(num) + (64'(den) >> 1)) / 64'(den);
		return num < 0 ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic signed [19:0] clamp20(input logic signed [63:0] x);
		if (x > 524287)
			return 20'sh7FFFF;
		if (x < -524288)
			return 20'sh80000;
		return x[19:0];
	endfunction

	// rotation turning a onto b, Rodrigues form without square root
	function automatic rot_t align_rotation(input pair_t p);
		rot_t o;
		logic signed [63:0] ax, ay, az, bx, by, bz, dotv, dm, qsum, lin, quad;
		logic signed [63:0] cr [3];
		logic signed [63:0] w [3];
		logic signed [63:0] sk [3][3];
		logic [63:0] mx, m;
		int sh;
		ax = p.ax; ay = p.ay; az = p.az; bx = p.bx; by = p.by; bz = p.bz;
		cr[0] = ay * bz - az * by;
		cr[1] = az * bx - ax * bz;
		cr[2] = ax * by - ay * bx;
		mx = 0;
		for (int i = 0; i < 3; i++)
			if (mag64(cr[i]) > mx)
				mx = mag64(cr[i]);
		if (mx == 0) begin
			for (int k = 0; k < 9; k++)
				o.r[k] = (k % 4 == 0) ? 20'sd16384 : 20'sd0;
			o.degen = 1'b1;
			return o;
		end
		dotv = ax * bx + ay * by + az * bz;
		dm = (64'sd1 <<< 28) - dotv;
		sh = 0;
		// normalise the cross product so the largest lane is in [2^14, 2^15)
		if (mx >= 32768) begin
			while ((mx >> sh) >= 32768)
				sh++;
		end else begin
			while ((mx << sh) < 16384)
				sh++;
		end
		qsum = 0;
		for (int i = 0; i < 3; i++) begin
			m = (mx >= 32768) ? (mag64(cr[i]) >> sh) : (mag64(cr[i]) << sh);
			w[i] = cr[i] < 0 ? -$signed(m) : $signed(m);
			qsum += w[i] * w[i];
		end
		sk[0][0] = 0;      sk[0][1] = -cr[2]; sk[0][2] = cr[1];
		sk[1][0] = cr[2];  sk[1][1] = 0;      sk[1][2] = -cr[0];
		sk[2][0] = -cr[1]; sk[2][1] = cr[0];  sk[2][2] = 0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				lin = sk[i][j] + ((i == j) ? dotv : 0);
				quad = div_nearest(w[i] * w[j] * dm, qsum <<< 14);
				o.r[i*3+j] = clamp20(div_nearest(lin, 16384) + quad);
			end
		o.degen = 1'b0;
		return o;
	endfunction

	function automatic logic signed [15:0] rand_field();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sd0;
			3: return 16'($urandom_range(0, 65535) >> $urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_pair(input logic signed [15:0] ax, ay, az, bx, by, bz);
		pair_t p;
		p.ax = ax; p.ay = ay; p.az = az; p.bx = bx; p.by = by; p.bz = bz;
		pending_pairs.insert(pending_pairs.size(), p);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at word %0d: %s got %0d expected %0d", n_checked, what, got, want);
		n_errors++;
	endtask

	// fill the queue of pending words
	initial begin
		pair_t p;
		int s;
		push_pair(16384, 0, 0, 0, 16384, 0);
		push_pair(0, 16384, 0, 16384, 0, 0);
		push_pair(16384, 0, 0, 16384, 0, 0);
		push_pair(16384, 0, 0, -16384, 0, 0);
		push_pair(0, 0, 0, 0, 0, 0);
		push_pair(0, 0, 0, 1000, 2000, 3000);
		push_pair(32767, 32767, 32767, -32768, -32768, -32768);
		push_pair(-32768, -32768, -32768, -32768, -32768, -32768);
		push_pair(32767, -32768, 32767, -32768, 32767, -32768);
		push_pair(-32768, 32767, 0, 32767, 32767, -32768);
		push_pair(1, 0, 0, 0, 1, 0);
		push_pair(1, 2, 3, 3, 2, 1);
		push_pair(-32768, 0, 0, 0, 0, -32768);
		push_pair(32767, 0, 0, 0, 32767, 0);
		push_pair(16384, 0, 0, 0, -16384, 0);
		push_pair(0, 0, 16384, 11585, 0, 11585);
		push_pair(16'shFFFF, 16'shFFFF, 16'shFFFF, 1, 1, 0);
		push_pair(100, 200, 300, 200, 400, 600);
		push_pair(-32768, 32767, -32768, 32767, -32768, 32767);
		push_pair(16384, 16384, 0, 0, 16384, 16384);
		for (int n = 0; n < N_RANDOM; n++) begin
			p.ax = rand_field(); p.ay = rand_field(); p.az = rand_field();
			p.bx = rand_field(); p.by = rand_field(); p.bz = rand_field();
			// some parallel or antiparallel pairs by integer scaling
			if ($urandom_range(0, 9) == 0) begin
				s = $urandom_range(0, 1) ? -1 : 1;
				p.ax = p.ax >>> 2; p.ay = p.ay >>> 2; p.az = p.az >>> 2;
				p.bx = 16'(s * p.ax); p.by = 16'(s * p.ay); p.bz = 16'(s * p.az);
			end
			pending_pairs.insert(pending_pairs.size(), p);
		end
		all_queued = 1'b1;
	end

	// reset, then count cycles up to the limit
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle == 7)
			arst_n <= 1'b1;
		if (cycle >= CYC_LIMIT) begin
			$display("timeout after %0d cycles", cycle);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// driver: bursts of words with random gaps
	int burst_left = 0;
	int gap_left = 0;
	initial begin
		vec.valid = 1'b0;
		vec.a_x = '0; vec.a_y = '0; vec.a_z = '0;
		vec.b_x = '0; vec.b_y = '0; vec.b_z = '0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (vec.valid && vec.ready) begin
				expected_rots.insert(expected_rots.size(),
					align_rotation(pending_pairs.pop_front()));
			end
			if (vec.valid && !vec.ready) begin
				// hold the word on offer
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				vec.valid <= 1'b0;
			end else if (pending_pairs.size() > 0) begin
				vec.valid <= 1'b1;
				vec.a_x <= pending_pairs[0].ax; vec.a_y <= pending_pairs[0].ay;
				vec.a_z <= pending_pairs[0].az; vec.b_x <= pending_pairs[0].bx;
				vec.b_y <= pending_pairs[0].by; vec.b_z <= pending_pairs[0].bz;
				if (burst_left > 0) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(0, 40);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				vec.valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern, with one long hold once the run is under way
	initial rot.ready = 1'b0;
	always @(posedge clk) begin
		if (!arst_n) begin
			rot.ready <= 1'b0;
		end else if (!hold_done && n_checked >= 300) begin
			rot.ready <= 1'b0;
			hold_cycles <= hold_cycles + 1;
			if (hold_cycles >= 200)
				hold_done <= 1'b1;
		end else if (cycle % 512 < 128) begin
			rot.ready <= 1'b1;
		end else begin
			rot.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// monitor: compare each result word with the oldest expectation
	always @(posedge clk) begin
		rot_t e;
		logic signed [19:0] g [9];
		if (arst_n && rot.valid && rot.ready) begin
			g = '{rot.r00, rot.r01, rot.r02, rot.r10, rot.r11, rot.r12,
				rot.r20, rot.r21, rot.r22};
			if (expected_rots.size() == 0) begin
				report_mismatch("unexpected word", 1, 0);
			end else begin
				e = expected_rots.pop_front();
				for (int k = 0; k < 9; k++) begin
					if (g[k] !== e.r[k])
						report_mismatch($sformatf("r%0d%0d", k / 3, k % 3), g[k], e.r[k]);
					if (e.r[k] == 20'sh7FFFF || e.r[k] == 20'sh80000)
						n_sat++;
				end
				if (rot.degenerate !== e.degen)
					report_mismatch("degenerate", rot.degenerate, e.degen);
				if (e.degen)
					n_degen++;
			end
			n_checked++;
		end
	end

	// end of run
	initial begin
		wait (arst_n && all_queued);
		wait (pending_pairs.size() == 0 && !vec.valid);
		wait (expected_rots.size() == 0);
		repeat (LATENCY * 4) @(posedge clk);
		if (expected_rots.size() != 0)
			report_mismatch("words left over", expected_rots.size(), 0);
		$display("checked %0d rotation words, %0d degenerate, %0d saturated entries",
			n_checked, n_degen, n_sat);
		$display("input bursts with gaps, patterned output stalls, one long output hold");
		if (n_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
